>>> hw/rtl/mstw_pkg.sv
// ----------------------------------------------------------------------------
// Timestamp watermark package
// Types and constants shared by the watermark sequencer and its comparator.
// ----------------------------------------------------------------------------
`default_nettype none

package mstw_pkg;

  localparam int unsigned TS_W   = 64;
  localparam int unsigned TICK_W = 32;
  localparam int unsigned SRC_W  = 3;
  localparam int unsigned REQ_W  = 8;
  localparam int unsigned CIDX_W = 2;
  localparam int unsigned CDAT_W = 32;

  localparam logic [TS_W-1:0] TS_ALL_ONES = {TS_W{1'b1}};

  localparam logic [1:0] OP_ARRIVAL = 2'd0;
  localparam logic [1:0] OP_QUERY   = 2'd1;
  localparam logic [1:0] OP_DELIVER = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_LATE     = 2'd2;
  localparam logic [1:0] ST_NO_WMARK = 2'd3;

  localparam logic [CIDX_W-1:0] CFG_REQUIRED = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_TIMEOUT  = 2'd1;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LATE_TS,
    S_LATE_SEQ,
    S_ARR_RD,
    S_ARR_WR,
    S_EXPIRE,
    S_Q_RD,
    S_Q_CHECK,
    S_Q_MIN,
    S_Q_END,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/mstw_cmp.sv
// ----------------------------------------------------------------------------
// Shared magnitude comparator
// Unsigned 64-bit less-than and equality, shared by every sequencer step that compares.
// ----------------------------------------------------------------------------
`default_nettype none

module mstw_cmp
  import mstw_pkg::*;
(
  input  wire logic [TS_W-1:0] a,
  input  wire logic [TS_W-1:0] b,
  output cmp_res_t             res
);

  assign res.lt = (a < b);
  assign res.eq = (a == b);

endmodule

`default_nettype wire

>>> hw/rtl/multi_source_timestamp_watermark_unit.sv
// ----------------------------------------------------------------------------
// Multi-source timestamp watermark unit
// Per-source watermark tracking and ordering checks for merging trace streams.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result appears on out_status and
// out_watermark for exactly one cycle with out_strobe high and must be taken
// in that cycle. A rejected arrival, a delivered-key record or an empty-buffer
// query goes from decode straight to the result; a late check compares keys
// and an accepted arrival then reads and writes its slot. A query visits the
// slots in turn, may end early at a required unseen slot, and uses one shared
// 64-bit comparator and one slot read port. Configuration writes are always accepted.
`default_nettype none

module multi_source_timestamp_watermark_unit
  import mstw_pkg::*;
#(
  parameter int unsigned SOURCES = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [TICK_W-1:0] in_now_tick,
  input  wire logic              in_entry_valid,
  input  wire logic [SRC_W-1:0]  in_source_id,
  input  wire logic [TS_W-1:0]   in_entry_timestamp,
  input  wire logic [TS_W-1:0]   in_entry_sequence,
  input  wire logic              in_buffer_nonempty,
  input  wire logic [TICK_W-1:0] in_first_buffered_tick,
  input  wire logic [TS_W-1:0]   in_newest_buffered_timestamp,

  output logic                   out_strobe,
  output logic [1:0]             out_status,
  output logic [TS_W-1:0]        out_watermark,

  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CDAT_W-1:0] cfg_data
);

  localparam int unsigned IDX_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int unsigned REQ_N = (SOURCES < REQ_W) ? SOURCES : REQ_W;

  state_t state_r, state_nxt;

  logic [REQ_W-1:0]  cfg_required_r;
  logic [TICK_W-1:0] cfg_timeout_r;

  logic              seen_r [SOURCES];
  logic [TS_W-1:0]   newest_r [SOURCES];
  logic [TICK_W-1:0] tick_r [SOURCES];

  logic              dlv_valid_r;
  logic [TS_W-1:0]   dlv_time_r;
  logic [SRC_W-1:0]  dlv_source_r;
  logic [TS_W-1:0]   dlv_seq_r;

  logic [1:0]        op_r;
  logic [TICK_W-1:0] now_r;
  logic              valid_r;
  logic [SRC_W-1:0]  src_r;
  logic [TS_W-1:0]   ts_r;
  logic [TS_W-1:0]   seq_r;
  logic              nonempty_r;
  logic [TICK_W-1:0] first_r;
  logic [TS_W-1:0]   newest_buf_r;

  logic              rd_seen_r;
  logic [TS_W-1:0]   rd_newest_r;
  logic [TICK_W-1:0] rd_tick_r;

  logic [IDX_W-1:0]  idx_r;
  logic              expired_r;
  logic              active_r;
  logic [TS_W-1:0]   min_r;
  logic [1:0]        res_status_r;
  logic [TS_W-1:0]   res_wm_r;

  logic [SOURCES-1:0]     req_vec;
  logic [IDX_W+SRC_W-1:0] src_ext;
  logic [IDX_W-1:0]       src_idx;
  logic [IDX_W-1:0]       rd_addr;
  logic                   src_req;
  logic                   idx_last;
  logic                   tmo_on;
  logic [TS_W-1:0]        cmp_a;
  logic [TS_W-1:0]        cmp_b;
  cmp_res_t               cmp_res;

  always_comb begin
    req_vec = '0;
    for (int i = 0; i < REQ_N; i++) begin
      req_vec[i] = cfg_required_r[i];
    end
  end

  assign src_ext  = {{IDX_W{1'b0}}, src_r};
  assign src_idx  = src_ext[IDX_W-1:0];
  assign src_req  = ({{(32-SRC_W){1'b0}}, src_r} < 32'(SOURCES)) && req_vec[src_idx];
  assign idx_last = (idx_r == IDX_W'(SOURCES - 1));
  assign tmo_on   = (cfg_timeout_r != '0);
  assign rd_addr  = (state_r == S_ARR_RD) ? src_idx : idx_r;

  mstw_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  always_comb begin
    cmp_a = ts_r;
    cmp_b = dlv_time_r;
    case (state_r)
      S_LATE_TS: begin
        cmp_a = ts_r;
        cmp_b = dlv_time_r;
      end
      S_LATE_SEQ: begin
        cmp_a = seq_r;
        cmp_b = dlv_seq_r;
      end
      S_ARR_WR: begin
        cmp_a = rd_newest_r;
        cmp_b = ts_r;
      end
      S_EXPIRE: begin
        cmp_a = {{(TS_W-TICK_W){1'b0}}, now_r - first_r};
        cmp_b = {{(TS_W-TICK_W){1'b0}}, cfg_timeout_r};
      end
      S_Q_CHECK: begin
        cmp_a = {{(TS_W-TICK_W){1'b0}}, now_r - rd_tick_r};
        cmp_b = {{(TS_W-TICK_W){1'b0}}, cfg_timeout_r};
      end
      S_Q_MIN: begin
        cmp_a = rd_newest_r;
        cmp_b = min_r;
      end
      default: begin
        cmp_a = ts_r;
        cmp_b = dlv_time_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (op_r)
          OP_ARRIVAL: begin
            if (!valid_r || !src_req) state_nxt = S_DONE;
            else if (dlv_valid_r)     state_nxt = S_LATE_TS;
            else                      state_nxt = S_ARR_RD;
          end
          OP_QUERY: begin
            state_nxt = nonempty_r ? S_EXPIRE : S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_LATE_TS: begin
        if (!cmp_res.eq)              state_nxt = cmp_res.lt ? S_DONE : S_ARR_RD;
        else if (src_r != dlv_source_r) state_nxt = (src_r < dlv_source_r) ? S_DONE : S_ARR_RD;
        else                          state_nxt = S_LATE_SEQ;
      end
      S_LATE_SEQ: begin
        state_nxt = (cmp_res.lt || cmp_res.eq) ? S_DONE : S_ARR_RD;
      end
      S_ARR_RD: state_nxt = S_ARR_WR;
      S_ARR_WR: state_nxt = S_DONE;
      S_EXPIRE: state_nxt = S_Q_RD;
      S_Q_RD:   state_nxt = S_Q_CHECK;
      S_Q_CHECK: begin
        if (!req_vec[idx_r]) begin
          state_nxt = idx_last ? S_Q_END : S_Q_RD;
        end else if (!rd_seen_r) begin
          if (!expired_r)    state_nxt = S_DONE;
          else               state_nxt = idx_last ? S_Q_END : S_Q_RD;
        end else if (tmo_on && !cmp_res.lt) begin
          state_nxt = idx_last ? S_Q_END : S_Q_RD;
        end else begin
          state_nxt = S_Q_MIN;
        end
      end
      S_Q_MIN: state_nxt = idx_last ? S_Q_END : S_Q_RD;
      S_Q_END: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state_r != S_IDLE);
    out_strobe    = (state_r == S_DONE);
    out_status    = res_status_r;
    out_watermark = res_wm_r;
    cfg_ready     = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_required_r <= '0;
      cfg_timeout_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REQUIRED: cfg_required_r <= cfg_data[REQ_W-1:0];
        CFG_TIMEOUT:  cfg_timeout_r  <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      op_r         <= in_opcode;
      now_r        <= in_now_tick;
      valid_r      <= in_entry_valid;
      src_r        <= in_source_id;
      ts_r         <= in_entry_timestamp;
      seq_r        <= in_entry_sequence;
      nonempty_r   <= in_buffer_nonempty;
      first_r      <= in_first_buffered_tick;
      newest_buf_r <= in_newest_buffered_timestamp;
    end
    if (state_r == S_ARR_RD || state_r == S_Q_RD) begin
      rd_newest_r <= newest_r[rd_addr];
      rd_tick_r   <= tick_r[rd_addr];
      rd_seen_r   <= seen_r[rd_addr];
    end
    if (state_r == S_ARR_WR) begin
      if (!rd_seen_r || cmp_res.lt) newest_r[src_idx] <= ts_r;
      tick_r[src_idx] <= now_r;
    end
    if (state_r == S_DECODE && op_r == OP_DELIVER) begin
      dlv_time_r   <= ts_r;
      dlv_source_r <= src_r;
      dlv_seq_r    <= seq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SOURCES; i++) begin
        seen_r[i] <= 1'b0;
      end
      dlv_valid_r <= 1'b0;
    end else begin
      if (state_r == S_ARR_WR) seen_r[src_idx] <= 1'b1;
      if (state_r == S_DECODE && op_r == OP_DELIVER) dlv_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_status_r <= ST_OK;
      res_wm_r     <= '0;
      idx_r        <= '0;
      expired_r    <= 1'b0;
      active_r     <= 1'b0;
      min_r        <= TS_ALL_ONES;
    end else begin
      case (state_r)
        S_DECODE: begin
          res_status_r <= ST_OK;
          res_wm_r     <= '0;
          idx_r        <= '0;
          active_r     <= 1'b0;
          min_r        <= TS_ALL_ONES;
          if (op_r == OP_ARRIVAL && (!valid_r || !src_req)) res_status_r <= ST_REJECT;
          if (op_r == OP_QUERY && !nonempty_r)              res_status_r <= ST_NO_WMARK;
        end
        S_LATE_TS: begin
          if ((!cmp_res.eq && cmp_res.lt) ||
              (cmp_res.eq && src_r != dlv_source_r && src_r < dlv_source_r)) begin
            res_status_r <= ST_LATE;
          end
        end
        S_LATE_SEQ: begin
          if (cmp_res.lt || cmp_res.eq) res_status_r <= ST_LATE;
        end
        S_EXPIRE: begin
          expired_r <= tmo_on && (first_r != '0) && !cmp_res.lt;
        end
        S_Q_CHECK: begin
          if (req_vec[idx_r] && !rd_seen_r && !expired_r) begin
            res_status_r <= ST_NO_WMARK;
          end else if (!req_vec[idx_r] || !rd_seen_r || (tmo_on && !cmp_res.lt)) begin
            if (!idx_last) idx_r <= idx_r + IDX_W'(1);
          end
        end
        S_Q_MIN: begin
          active_r <= 1'b1;
          if (cmp_res.lt) min_r <= rd_newest_r;
          if (!idx_last) idx_r <= idx_r + IDX_W'(1);
        end
        S_Q_END: begin
          res_wm_r <= active_r ? min_r : newest_buf_r;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> verif/watermark_result_checker.sv
// ----------------------------------------------------------------------------
// Watermark result checker
// Watches the item, result and register channels of the watermark unit. It
// keeps its own copy of the per-source state and registers, works out the
// reply to each accepted item, and compares every strobed result with the
// oldest reply still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module watermark_result_checker
  import mstw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [TICK_W-1:0] in_now_tick,
  input  logic              in_entry_valid,
  input  logic [SRC_W-1:0]  in_source_id,
  input  logic [TS_W-1:0]   in_entry_timestamp,
  input  logic [TS_W-1:0]   in_entry_sequence,
  input  logic              in_buffer_nonempty,
  input  logic [TICK_W-1:0] in_first_buffered_tick,
  input  logic [TS_W-1:0]   in_newest_buffered_timestamp,
  input  logic              out_strobe,
  input  logic [1:0]        out_status,
  input  logic [TS_W-1:0]   out_watermark,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CDAT_W-1:0] cfg_data,
  output int unsigned       mismatch_count,
  output int unsigned       outstanding
);

  localparam int unsigned NUM_SRC = 8;

  typedef struct packed {
    logic [1:0]      status;
    logic [TS_W-1:0] watermark;
  } reply_t;

  reply_t            queued_replies[$];
  logic [REQ_W-1:0]  required_mask;
  logic [TICK_W-1:0] flush_ticks;
  logic              src_seen[NUM_SRC];
  logic [TS_W-1:0]   src_newest[NUM_SRC];
  logic [TICK_W-1:0] src_tick[NUM_SRC];
  logic              dlv_valid;
  logic [TS_W-1:0]   dlv_ts;
  logic [SRC_W-1:0]  dlv_src;
  logic [TS_W-1:0]   dlv_seq;

  function automatic reply_t watermark_step();
    reply_t          r;
    logic            late;
    logic            expired;
    logic            blocked;
    logic            active;
    logic [TS_W-1:0] lowest;
    r.status = ST_OK;
    r.watermark = '0;
    case (in_opcode)
      OP_ARRIVAL: begin
        late = dlv_valid &&
               ((in_entry_timestamp != dlv_ts) ? (in_entry_timestamp < dlv_ts) :
                (in_source_id != dlv_src) ? (in_source_id < dlv_src) :
                (in_entry_sequence <= dlv_seq));
        if (!in_entry_valid || !required_mask[in_source_id]) begin
          r.status = ST_REJECT;
        end else if (late) begin
          r.status = ST_LATE;
        end else begin
          if (!src_seen[in_source_id] || in_entry_timestamp > src_newest[in_source_id]) begin
            src_newest[in_source_id] = in_entry_timestamp;
          end
          src_tick[in_source_id] = in_now_tick;
          src_seen[in_source_id] = 1'b1;
        end
      end
      OP_QUERY: begin
        if (!in_buffer_nonempty) begin
          r.status = ST_NO_WMARK;
        end else begin
          expired = (flush_ticks != '0) && (in_first_buffered_tick != '0) &&
                    (TICK_W'(in_now_tick - in_first_buffered_tick) >= flush_ticks);
          blocked = 1'b0;
          active = 1'b0;
          lowest = TS_ALL_ONES;
          for (int i = 0; i < NUM_SRC && !blocked; i++) begin
            if (required_mask[i]) begin
              if (!src_seen[i]) begin
                blocked = !expired;
              end else if (flush_ticks == '0 ||
                           TICK_W'(in_now_tick - src_tick[i]) < flush_ticks) begin
                active = 1'b1;
                if (src_newest[i] < lowest) begin
                  lowest = src_newest[i];
                end
              end
            end
          end
          if (blocked) begin
            r.status = ST_NO_WMARK;
          end else begin
            r.watermark = active ? lowest : in_newest_buffered_timestamp;
          end
        end
      end
      OP_DELIVER: begin
        dlv_ts = in_entry_timestamp;
        dlv_src = in_source_id;
        dlv_seq = in_entry_sequence;
        dlv_valid = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      queued_replies.delete();
      required_mask = '0;
      flush_ticks = '0;
      for (int i = 0; i < NUM_SRC; i++) begin
        src_seen[i] = 1'b0;
        src_newest[i] = '0;
        src_tick[i] = '0;
      end
      dlv_valid = 1'b0;
      dlv_ts = '0;
      dlv_src = '0;
      dlv_seq = '0;
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REQUIRED: required_mask = cfg_data[REQ_W-1:0];
          CFG_TIMEOUT:  flush_ticks = cfg_data;
          default: begin
          end
        endcase
      end
      if (out_strobe) begin
        if (queued_replies.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, got status %0d watermark %h",
                   $time, out_status, out_watermark);
        end else begin
          want = queued_replies.pop_front();
          if (out_status !== want.status) begin
            mismatch_count++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
          end
          if (out_watermark !== want.watermark) begin
            mismatch_count++;
            $display("%0t: watermark expected %h, got %h",
                     $time, want.watermark, out_watermark);
          end
        end
      end
      if (start && !busy) begin
        queued_replies.push_back(watermark_step());
      end
    end
    outstanding = queued_replies.size();
  end

endmodule

>>> verif/multi_source_timestamp_watermark_unit_tb.sv
// ----------------------------------------------------------------------------
// Multi-source timestamp watermark unit testbench
// Drives directed items for the ordering, blocking and timeout rules, then
// random phases under several register settings, with random gaps between
// items in all but the last. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multi_source_timestamp_watermark_unit_tb;
  import mstw_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_opcode;
  logic [TICK_W-1:0] in_now_tick;
  logic              in_entry_valid;
  logic [SRC_W-1:0]  in_source_id;
  logic [TS_W-1:0]   in_entry_timestamp;
  logic [TS_W-1:0]   in_entry_sequence;
  logic              in_buffer_nonempty;
  logic [TICK_W-1:0] in_first_buffered_tick;
  logic [TS_W-1:0]   in_newest_buffered_timestamp;
  logic              out_strobe;
  logic [1:0]        out_status;
  logic [TS_W-1:0]   out_watermark;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [CDAT_W-1:0] cfg_data;
  int unsigned       mismatch_count;
  int unsigned       outstanding;
  logic [TICK_W-1:0] tick_now;
  logic [TS_W-1:0]   ts_base;

  multi_source_timestamp_watermark_unit u_dut (
    .clk                          (clk),
    .rst_n                        (rst_n),
    .start                        (start),
    .busy                         (busy),
    .in_opcode                    (in_opcode),
    .in_now_tick                  (in_now_tick),
    .in_entry_valid               (in_entry_valid),
    .in_source_id                 (in_source_id),
    .in_entry_timestamp           (in_entry_timestamp),
    .in_entry_sequence            (in_entry_sequence),
    .in_buffer_nonempty           (in_buffer_nonempty),
    .in_first_buffered_tick       (in_first_buffered_tick),
    .in_newest_buffered_timestamp (in_newest_buffered_timestamp),
    .out_strobe                   (out_strobe),
    .out_status                   (out_status),
    .out_watermark                (out_watermark),
    .cfg_valid                    (cfg_valid),
    .cfg_ready                    (cfg_ready),
    .cfg_index                    (cfg_index),
    .cfg_data                     (cfg_data)
  );

  watermark_result_checker u_checker (
    .clk                          (clk),
    .rst_n                        (rst_n),
    .start                        (start),
    .busy                         (busy),
    .in_opcode                    (in_opcode),
    .in_now_tick                  (in_now_tick),
    .in_entry_valid               (in_entry_valid),
    .in_source_id                 (in_source_id),
    .in_entry_timestamp           (in_entry_timestamp),
    .in_entry_sequence            (in_entry_sequence),
    .in_buffer_nonempty           (in_buffer_nonempty),
    .in_first_buffered_tick       (in_first_buffered_tick),
    .in_newest_buffered_timestamp (in_newest_buffered_timestamp),
    .out_strobe                   (out_strobe),
    .out_status                   (out_status),
    .out_watermark                (out_watermark),
    .cfg_valid                    (cfg_valid),
    .cfg_ready                    (cfg_ready),
    .cfg_index                    (cfg_index),
    .cfg_data                     (cfg_data),
    .mismatch_count               (mismatch_count),
    .outstanding                  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("multi_source_timestamp_watermark_unit regression: fail");
    $finish;
  end

  task automatic issue(input logic [1:0] op, input logic [TICK_W-1:0] now,
                       input logic ok, input logic [SRC_W-1:0] src,
                       input logic [TS_W-1:0] ts, input logic [TS_W-1:0] seq,
                       input logic nonempty, input logic [TICK_W-1:0] first,
                       input logic [TS_W-1:0] newest);
    @(negedge clk);
    start = 1'b1;
    in_opcode = op;
    in_now_tick = now;
    in_entry_valid = ok;
    in_source_id = src;
    in_entry_timestamp = ts;
    in_entry_sequence = seq;
    in_buffer_nonempty = nonempty;
    in_first_buffered_tick = first;
    in_newest_buffered_timestamp = newest;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int unsigned cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Most items follow the running tick and timestamp so that ordering checks,
  // idle sources and minimum searches are hit; the rest is unshaped noise.
  task automatic run_phase(input logic [REQ_W-1:0] req, input logic [CDAT_W-1:0] tmo,
                           input int unsigned items, input int unsigned step,
                           input bit quiet);
    logic [SRC_W-1:0] src;
    int unsigned      pick;
    settle();
    write_reg(CFG_REQUIRED, CDAT_W'(req));
    write_reg(CFG_TIMEOUT, tmo);
    repeat (items) begin
      pick = $urandom_range(0, 99);
      tick_now += $urandom_range(0, step);
      if (pick < 20) begin
        issue(2'($urandom_range(0, 3)), $urandom, 1'($urandom), 3'($urandom),
              {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom), $urandom,
              {$urandom, $urandom});
      end else if (pick < 60) begin
        do src = 3'($urandom); while (req != '0 && pick >= 24 && !req[src]);
        issue(OP_ARRIVAL, tick_now, $urandom_range(0, 19) != 0, src,
              ts_base + TS_W'($urandom_range(0, 6)) - TS_W'(3),
              TS_W'($urandom_range(0, 7)), 1'($urandom), $urandom, {$urandom, $urandom});
      end else if (pick < 88) begin
        issue(OP_QUERY, tick_now, 1'($urandom), 3'($urandom), {$urandom, $urandom},
              {$urandom, $urandom}, $urandom_range(0, 9) != 0,
              ($urandom_range(0, 3) == 0) ? '0 : tick_now - $urandom_range(0, 128),
              {$urandom, $urandom});
      end else if (pick < 97) begin
        issue(OP_DELIVER, tick_now, 1'($urandom), 3'($urandom),
              ts_base - TS_W'($urandom_range(0, 6)), TS_W'($urandom_range(0, 7)),
              1'($urandom), $urandom, {$urandom, $urandom});
      end else begin
        issue(OP_UNUSED, tick_now, 1'($urandom), 3'($urandom), {$urandom, $urandom},
              {$urandom, $urandom}, 1'($urandom), $urandom, {$urandom, $urandom});
      end
      ts_base += TS_W'($urandom_range(0, 3));
      if (!quiet && $urandom_range(0, 4) == 0) begin
        pause($urandom_range(1, 16));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_ARRIVAL;
    in_now_tick = '0;
    in_entry_valid = 1'b0;
    in_source_id = '0;
    in_entry_timestamp = '0;
    in_entry_sequence = '0;
    in_buffer_nonempty = 1'b0;
    in_first_buffered_tick = '0;
    in_newest_buffered_timestamp = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_REQUIRED;
    cfg_data = '0;
    tick_now = 32'd2000;
    ts_base = 64'h0000_0100_0000_0000;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // With no source required, a query gives the newest buffered timestamp.
    issue(OP_QUERY, 0, 0, 0, 0, 0, 1, 0, TS_ALL_ONES);
    issue(OP_ARRIVAL, 0, 1, 5, 1, 1, 0, 0, 0);
    settle();
    write_reg(CFG_REQUIRED, 32'h0000_00FF);
    write_reg(CFG_TIMEOUT, 32'd100);

    // Empty buffer, unseen sources blocking, and an expired buffer wait.
    issue(OP_QUERY, 500, 1, 0, 0, 0, 0, 300, 5);
    issue(OP_QUERY, 500, 1, 0, 0, 0, 1, 0, 7);
    issue(OP_QUERY, 350, 1, 0, 0, 0, 1, 300, 9);
    issue(OP_QUERY, 500, 1, 0, 0, 0, 1, 300, 64'h0123_4567_89AB_CDEF);
    issue(OP_ARRIVAL, 1000, 0, 3, 10, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++) begin
      issue(OP_ARRIVAL, 1000, 1, 3'(i),
            (i == 0) ? '0 : (i == 7) ? TS_ALL_ONES : TS_W'(100 + 10 * i),
            (i == 7) ? TS_ALL_ONES : '0, 0, 0, 0);
    end
    issue(OP_QUERY, 1050, 1, 0, 0, 0, 1, 0, 1);
    issue(OP_ARRIVAL, 1000, 1, 0, 50, 0, 0, 0, 0);
    issue(OP_ARRIVAL, 1000, 1, 0, 20, 0, 0, 0, 0);
    issue(OP_QUERY, 1050, 1, 0, 0, 0, 1, 0, 1);

    // Late entries against the delivered key, then idle sources being skipped.
    issue(OP_DELIVER, 0, 0, 1, 110, 5, 0, 0, 0);
    issue(OP_ARRIVAL, 1150, 1, 1, 100, 9, 0, 0, 0);
    issue(OP_ARRIVAL, 1150, 1, 0, 110, 9, 0, 0, 0);
    issue(OP_ARRIVAL, 1150, 1, 1, 110, 5, 0, 0, 0);
    issue(OP_ARRIVAL, 1150, 1, 1, 110, 6, 0, 0, 0);
    issue(OP_QUERY, 1200, 1, 0, 0, 0, 1, 0, 2);
    issue(OP_QUERY, 1300, 1, 0, 0, 0, 1, 0, 64'hFEDC_BA98_7654_3210);
    issue(OP_UNUSED, 1300, 1, 7, TS_ALL_ONES, TS_ALL_ONES, 1, 32'hFFFF_FFFF, TS_ALL_ONES);

    run_phase(8'hFF, 32'd0, 120, 40, 0);
    run_phase(8'($urandom_range(1, 255)), $urandom_range(4, 64), 110, 12, 0);
    run_phase(8'hFF, 32'hFFFF_FFFF, 110, 1000, 0);
    run_phase(8'h00, $urandom_range(4, 64), 60, 12, 0);
    run_phase(8'($urandom_range(1, 255)), 32'd1, 100, 2, 0);
    tick_now = 32'hFFFF_FFC0;
    run_phase(8'($urandom_range(1, 255)), $urandom_range(4, 64), 110, 12, 1);

    settle();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("multi_source_timestamp_watermark_unit regression: pass");
    end else begin
      $display("multi_source_timestamp_watermark_unit regression: fail");
    end
    $finish;
  end

endmodule
